// File: src/rudv_pkg.sv
// Package for the radial undistortion unit-vector block: sequencer types,
// micro-op table and saturating fixed-point helpers.
// No dependencies.
`default_nettype none

package rudv_pkg;

  typedef enum logic [2:0] {
    S_IDLE, S_READ, S_EXEC, S_MUL, S_DIV, S_SQRT, S_WB
  } state_t;

  typedef enum logic [3:0] {
    OP_ADD, OP_SUB, OP_MUL, OP_MULC, OP_DIV, OP_TOLX, OP_TOLY,
    OP_SQA, OP_SQB, OP_SQRT, OP_BRK, OP_BRZ, OP_JMP, OP_EMIT
  } op_t;

  typedef enum logic [4:0] {
    SRC_X, SRC_Y, SRC_XX, SRC_XY, SRC_YY, SRC_R, SRC_G, SRC_FX,
    SRC_FY, SRC_H, SRC_J0, SRC_J1, SRC_J3, SRC_DET, SRC_T0, SRC_T1,
    SRC_XD, SRC_YD, SRC_ONE, SRC_K1, SRC_K1X, SRC_K2, SRC_PS, SRC_N, SRC_ZERO
  } src_t;

  typedef enum logic [1:0] {LANE_NONE, LANE_B, LANE_H, LANE_V} lane_t;

  typedef enum logic [2:0] {
    REG_CENTRE_COL, REG_CENTRE_ROW, REG_PIXEL_SCALE, REG_K1_COEF,
    REG_K2_COEF, REG_ITER_LIMIT, REG_RESIDUAL_TOL_SQ
  } cfg_reg_t;

  typedef logic [5:0] upc_t;

  typedef struct packed {
    op_t        op;
    src_t       a;
    src_t       b;
    src_t       d;
    logic [6:0] sh;
    lane_t      lane;
  } uop_t;

  localparam upc_t L_TOP  = 6'd2;
  localparam upc_t L_OUT  = 6'd40;
  localparam upc_t L_LAST = 6'd48;

  localparam logic [6:0] MUL_LAST  = 7'd4;
  localparam logic [6:0] DIV_LAST  = 7'd92;
  localparam logic [6:0] SQRT_LAST = 7'd47;

  localparam logic [5:0] ITER_LIMIT_RST = 6'd50;

  localparam logic signed [63:0] ONE_Q30 = 64'sh0000_0000_4000_0000;
  localparam logic signed [63:0] SAT_POS = 64'sh3FFF_FFFF_FFFF_FFFF;
  localparam logic signed [63:0] TAN_LIM = 64'sh0000_4000_0000_0000;
  localparam logic [95:0]        NSQ_BASE = 96'h1 << 60;

  function automatic uop_t uop(input op_t op, input src_t a, input src_t b,
                               input src_t d, input logic [6:0] sh,
                               input lane_t lane);
    uop_t u;
    u.op = op; u.a = a; u.b = b; u.d = d; u.sh = sh; u.lane = lane;
    return u;
  endfunction

  function automatic uop_t ucode(input upc_t pc);
    uop_t u;
    case (pc)
      6'd0:  u = uop(OP_ADD,  SRC_XD,  SRC_ZERO, SRC_X,   7'd0,  LANE_NONE);
      6'd1:  u = uop(OP_ADD,  SRC_YD,  SRC_ZERO, SRC_Y,   7'd0,  LANE_NONE);
      6'd2:  u = uop(OP_MUL,  SRC_X,   SRC_X,    SRC_XX,  7'd16, LANE_NONE);
      6'd3:  u = uop(OP_MUL,  SRC_X,   SRC_Y,    SRC_XY,  7'd16, LANE_NONE);
      6'd4:  u = uop(OP_MUL,  SRC_Y,   SRC_Y,    SRC_YY,  7'd16, LANE_NONE);
      6'd5:  u = uop(OP_ADD,  SRC_XX,  SRC_YY,   SRC_R,   7'd0,  LANE_NONE);
      6'd6:  u = uop(OP_MUL,  SRC_K1,  SRC_R,    SRC_T0,  7'd26, LANE_NONE);
      6'd7:  u = uop(OP_ADD,  SRC_ONE, SRC_T0,   SRC_T0,  7'd0,  LANE_NONE);
      6'd8:  u = uop(OP_MUL,  SRC_R,   SRC_R,    SRC_T1,  7'd32, LANE_NONE);
      6'd9:  u = uop(OP_MUL,  SRC_K2,  SRC_T1,   SRC_T1,  7'd42, LANE_NONE);
      6'd10: u = uop(OP_ADD,  SRC_T0,  SRC_T1,   SRC_G,   7'd0,  LANE_NONE);
      6'd11: u = uop(OP_MUL,  SRC_G,   SRC_X,    SRC_FX,  7'd30, LANE_NONE);
      6'd12: u = uop(OP_SUB,  SRC_FX,  SRC_XD,   SRC_FX,  7'd0,  LANE_NONE);
      6'd13: u = uop(OP_MUL,  SRC_G,   SRC_Y,    SRC_FY,  7'd30, LANE_NONE);
      6'd14: u = uop(OP_SUB,  SRC_FY,  SRC_YD,   SRC_FY,  7'd0,  LANE_NONE);
      6'd15: u = uop(OP_TOLX, SRC_FX,  SRC_FX,   SRC_T0,  7'd0,  LANE_NONE);
      6'd16: u = uop(OP_TOLY, SRC_FY,  SRC_FY,   SRC_T0,  7'd0,  LANE_NONE);
      6'd17: u = uop(OP_BRK,  SRC_ZERO, SRC_ZERO, SRC_T0, 7'd0,  LANE_NONE);
      6'd18: u = uop(OP_MUL,  SRC_K2,  SRC_R,    SRC_T0,  7'd38, LANE_NONE);
      6'd19: u = uop(OP_ADD,  SRC_K1X, SRC_T0,   SRC_H,   7'd0,  LANE_NONE);
      6'd20: u = uop(OP_MUL,  SRC_H,   SRC_XX,   SRC_T0,  7'd34, LANE_NONE);
      6'd21: u = uop(OP_ADD,  SRC_G,   SRC_T0,   SRC_J0,  7'd0,  LANE_NONE);
      6'd22: u = uop(OP_MUL,  SRC_H,   SRC_XY,   SRC_J1,  7'd34, LANE_NONE);
      6'd23: u = uop(OP_MUL,  SRC_H,   SRC_YY,   SRC_T0,  7'd34, LANE_NONE);
      6'd24: u = uop(OP_ADD,  SRC_G,   SRC_T0,   SRC_J3,  7'd0,  LANE_NONE);
      6'd25: u = uop(OP_MUL,  SRC_J0,  SRC_J3,   SRC_T0,  7'd30, LANE_NONE);
      6'd26: u = uop(OP_MUL,  SRC_J1,  SRC_J1,   SRC_T1,  7'd30, LANE_NONE);
      6'd27: u = uop(OP_SUB,  SRC_T0,  SRC_T1,   SRC_DET, 7'd0,  LANE_NONE);
      6'd28: u = uop(OP_BRZ,  SRC_DET, SRC_ZERO, SRC_T0,  7'd0,  LANE_NONE);
      6'd29: u = uop(OP_MUL,  SRC_J3,  SRC_FX,   SRC_T0,  7'd30, LANE_NONE);
      6'd30: u = uop(OP_MUL,  SRC_J1,  SRC_FY,   SRC_T1,  7'd30, LANE_NONE);
      6'd31: u = uop(OP_SUB,  SRC_T0,  SRC_T1,   SRC_T0,  7'd0,  LANE_NONE);
      6'd32: u = uop(OP_DIV,  SRC_T0,  SRC_DET,  SRC_T0,  7'd0,  LANE_NONE);
      6'd33: u = uop(OP_SUB,  SRC_X,   SRC_T0,   SRC_X,   7'd0,  LANE_NONE);
      6'd34: u = uop(OP_MUL,  SRC_J0,  SRC_FY,   SRC_T0,  7'd30, LANE_NONE);
      6'd35: u = uop(OP_MUL,  SRC_J1,  SRC_FX,   SRC_T1,  7'd30, LANE_NONE);
      6'd36: u = uop(OP_SUB,  SRC_T0,  SRC_T1,   SRC_T0,  7'd0,  LANE_NONE);
      6'd37: u = uop(OP_DIV,  SRC_T0,  SRC_DET,  SRC_T0,  7'd0,  LANE_NONE);
      6'd38: u = uop(OP_SUB,  SRC_Y,   SRC_T0,   SRC_Y,   7'd0,  LANE_NONE);
      6'd39: u = uop(OP_JMP,  SRC_ZERO, SRC_ZERO, SRC_T0, 7'd0,  LANE_NONE);
      6'd40: u = uop(OP_MULC, SRC_PS,  SRC_X,    SRC_XX,  7'd18, LANE_NONE);
      6'd41: u = uop(OP_MULC, SRC_PS,  SRC_Y,    SRC_YY,  7'd18, LANE_NONE);
      6'd42: u = uop(OP_SQA,  SRC_XX,  SRC_XX,   SRC_T0,  7'd0,  LANE_NONE);
      6'd43: u = uop(OP_SQB,  SRC_YY,  SRC_YY,   SRC_T0,  7'd0,  LANE_NONE);
      6'd44: u = uop(OP_SQRT, SRC_ZERO, SRC_ZERO, SRC_T0, 7'd0,  LANE_NONE);
      6'd45: u = uop(OP_DIV,  SRC_ONE, SRC_N,    SRC_T0,  7'd0,  LANE_B);
      6'd46: u = uop(OP_DIV,  SRC_XX,  SRC_N,    SRC_T0,  7'd0,  LANE_H);
      6'd47: u = uop(OP_DIV,  SRC_YY,  SRC_N,    SRC_T0,  7'd0,  LANE_V);
      default: u = uop(OP_EMIT, SRC_ZERO, SRC_ZERO, SRC_T0, 7'd0, LANE_NONE);
    endcase
    return u;
  endfunction

  function automatic logic [63:0] mag(input logic signed [63:0] a);
    return a[63] ? 64'(-a) : 64'(a);
  endfunction

  function automatic logic signed [63:0] sat_mag(input logic [127:0] m, input logic neg);
    logic [63:0] v;
    v = (m[127:62] != '0) ? 64'(SAT_POS) : {2'b00, m[61:0]};
    return neg ? -$signed(v) : $signed(v);
  endfunction

  function automatic logic signed [63:0] sadd(input logic signed [63:0] a,
                                              input logic signed [63:0] b);
    logic signed [63:0] s;
    s = a + b;
    if (s > SAT_POS) return SAT_POS;
    if (s < -SAT_POS) return -SAT_POS;
    return s;
  endfunction

endpackage

`default_nettype wire

// File: src/radial_undistort_unit_vector.sv
// Radial undistortion and pinhole unit vector for star centroids.
// Uses rudv_pkg for the micro-op table, sequencer types and arithmetic helpers.
//
// One centroid word enters at a time; s_axis_tready is high only while the
// block is idle. A small sequencer steps a micro-op table through one shared
// 32x32 multiplier (four partial products), a one bit a cycle divider and a
// two bits a cycle square root. The result word waits in an output register,
// and the next centroid is taken while it waits.
`default_nettype none

module radial_undistort_unit_vector #(
  parameter int PIXEL_FRAC_BITS = 8,
  parameter int IMAGE_SIZE_BITS = 12,
  localparam int PosW = IMAGE_SIZE_BITS + PIXEL_FRAC_BITS,
  localparam int InW  = ((2 * PosW + 7) / 8) * 8
) (
  input  logic           clk,
  input  logic           rst,
  input  logic           s_axis_tvalid,
  output logic           s_axis_tready,
  input  logic [InW-1:0] s_axis_tdata,   // centroid_row, centroid_col
  input  logic           s_axis_tlast,   // is_last
  output logic           m_axis_tvalid,
  input  logic           m_axis_tready,
  output logic [95:0]    m_axis_tdata,   // vec_boresight, vec_horizontal, vec_vertical
  output logic [0:0]     m_axis_tuser,   // singular
  output logic           m_axis_tlast,   // is_last_out
  input  logic           cfg_valid,
  output logic           cfg_ready,
  input  logic [2:0]     cfg_index,
  input  logic [31:0]    cfg_data
);
  import rudv_pkg::*;

  logic [IMAGE_SIZE_BITS-1:0] centre_col, centre_row;
  logic [31:0]                pixel_scale;
  logic signed [31:0]         k1_coef, k2_coef;
  logic [5:0]                 iter_limit;
  logic [15:0]                residual_tol_sq;

  state_t state, state_next;
  upc_t   pc;
  logic [5:0] iter;
  logic singular_r, last_r, tol_flag;
  uop_t uc;

  logic signed [63:0] rf [16];
  logic signed [63:0] rd_a, rd_b, opa, opb, xd, yd;
  logic signed [PosW:0] xdiff, ydiff;

  logic [63:0]  ma, mb, ma_in, mb_in, pp;
  logic [1:0]   pk;
  logic [127:0] acc;
  logic         neg;
  logic [6:0]   count;
  logic [92:0]  num, q;
  logic [63:0]  dv, rem;
  logic [64:0]  rem_sh;
  logic [95:0]  nsq, rad;
  logic [47:0]  root;
  logic [49:0]  srem;
  logic [51:0]  ssh, trial;
  logic [31:0]  res_b, res_h, res_v;

  logic               rf_we, emit_go, above;
  logic signed [63:0] rf_wdata, addres, mulres, mulclamp, divres;

  assign cfg_ready = 1'b1;
  assign uc = ucode(pc);

  always_ff @(posedge clk) begin
    if (rst) begin
      centre_col      <= '0;
      centre_row      <= '0;
      pixel_scale     <= '0;
      k1_coef         <= '0;
      k2_coef         <= '0;
      iter_limit      <= ITER_LIMIT_RST;
      residual_tol_sq <= '0;
    end else if (cfg_valid) begin
      case (cfg_index)
        REG_CENTRE_COL:      centre_col      <= cfg_data[IMAGE_SIZE_BITS-1:0];
        REG_CENTRE_ROW:      centre_row      <= cfg_data[IMAGE_SIZE_BITS-1:0];
        REG_PIXEL_SCALE:     pixel_scale     <= cfg_data;
        REG_K1_COEF:         k1_coef         <= $signed(cfg_data);
        REG_K2_COEF:         k2_coef         <= $signed(cfg_data);
        REG_ITER_LIMIT:      iter_limit      <= cfg_data[5:0];
        REG_RESIDUAL_TOL_SQ: residual_tol_sq <= cfg_data[15:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    xdiff = $signed({1'b0, (PosW'(centre_col) << PIXEL_FRAC_BITS)})
          - $signed({1'b0, s_axis_tdata[2*PosW-1:PosW]});
    ydiff = $signed({1'b0, (PosW'(centre_row) << PIXEL_FRAC_BITS)})
          - $signed({1'b0, s_axis_tdata[PosW-1:0]});
  end

  function automatic logic signed [63:0] src_val(input src_t s, input logic signed [63:0] rd);
    case (s)
      SRC_XD:   return xd;
      SRC_YD:   return yd;
      SRC_ONE:  return ONE_Q30;
      SRC_K1:   return 64'(k1_coef);
      SRC_K1X:  return 64'(k1_coef) <<< 9;
      SRC_K2:   return 64'(k2_coef);
      SRC_PS:   return $signed({32'b0, pixel_scale});
      SRC_N:    return $signed({16'b0, root});
      SRC_ZERO: return '0;
      default:  return rd;
    endcase
  endfunction

  always_comb begin
    opa   = src_val(uc.a, rd_a);
    opb   = src_val(uc.b, rd_b);
    ma_in = mag(opa);
    mb_in = mag(opb);
  end

  always_ff @(posedge clk) begin
    if (rf_we) begin
      rf[uc.d[3:0]] <= rf_wdata;
    end
    rd_a <= rf[uc.a[3:0]];
    rd_b <= rf[uc.b[3:0]];
  end

  always_comb begin
    addres   = sadd(opa, (uc.op == OP_SUB) ? -opb : opb);
    mulres   = sat_mag(acc >> uc.sh, neg);
    mulclamp = (mulres > TAN_LIM) ? TAN_LIM : ((mulres < -TAN_LIM) ? -TAN_LIM : mulres);
    divres   = (dv == '0) ? 64'sd0 : sat_mag({35'b0, q}, neg);
    above    = (acc[127:64] != '0) || (acc[63:0] > {32'b0, residual_tol_sq, 16'b0});
    rem_sh   = {rem, num[92]};
    ssh      = {srem, rad[95:94]};
    trial    = {2'b00, root, 2'b01};
  end

  always_comb begin
    state_next = state;
    case (state)
      S_IDLE: if (s_axis_tvalid) state_next = S_READ;
      S_READ: state_next = S_EXEC;
      S_EXEC: begin
        case (uc.op)
          OP_MUL, OP_MULC, OP_TOLX, OP_TOLY, OP_SQA, OP_SQB: state_next = S_MUL;
          OP_DIV:  state_next = S_DIV;
          OP_SQRT: state_next = S_SQRT;
          OP_EMIT: if (!m_axis_tvalid || m_axis_tready) state_next = S_IDLE;
          default: state_next = S_READ;
        endcase
      end
      S_MUL:  if (count == MUL_LAST) state_next = S_WB;
      S_DIV:  if (count == DIV_LAST) state_next = S_WB;
      S_SQRT: if (count == SQRT_LAST) state_next = S_WB;
      S_WB:   state_next = S_READ;
      default: state_next = S_IDLE;
    endcase
  end

  always_comb begin
    s_axis_tready = (state == S_IDLE);
    rf_we    = 1'b0;
    rf_wdata = addres;
    emit_go  = 1'b0;
    case (state)
      S_EXEC: begin
        case (uc.op)
          OP_ADD, OP_SUB: rf_we = 1'b1;
          OP_EMIT: emit_go = !m_axis_tvalid || m_axis_tready;
          default: ;
        endcase
      end
      S_WB: begin
        case (uc.op)
          OP_MUL:  begin rf_we = 1'b1; rf_wdata = mulres;   end
          OP_MULC: begin rf_we = 1'b1; rf_wdata = mulclamp; end
          OP_DIV:  begin rf_we = 1'b1; rf_wdata = divres;   end
          default: ;
        endcase
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state         <= S_IDLE;
      pc            <= '0;
      iter          <= '0;
      singular_r    <= 1'b0;
      m_axis_tvalid <= 1'b0;
    end else begin
      state <= state_next;
      case (state)
        S_IDLE: begin
          if (s_axis_tvalid) begin
            pc         <= '0;
            iter       <= '0;
            singular_r <= 1'b0;
          end
        end
        S_EXEC: begin
          case (uc.op)
            OP_ADD, OP_SUB: pc <= pc + 6'd1;
            OP_BRK: pc <= (!tol_flag || iter >= iter_limit) ? L_OUT : pc + 6'd1;
            OP_BRZ: begin
              if (opa == '0) begin
                singular_r <= 1'b1;
                pc         <= L_OUT;
              end else begin
                pc <= pc + 6'd1;
              end
            end
            OP_JMP: begin
              iter <= iter + 6'd1;
              pc   <= L_TOP;
            end
            default: ;
          endcase
        end
        S_WB: pc <= pc + 6'd1;
        default: ;
      endcase
      if (emit_go) begin
        m_axis_tvalid <= 1'b1;
      end else if (m_axis_tready) begin
        m_axis_tvalid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (state == S_IDLE && s_axis_tvalid) begin
      xd     <= 64'(xdiff) <<< (16 - PIXEL_FRAC_BITS);
      yd     <= 64'(ydiff) <<< (16 - PIXEL_FRAC_BITS);
      last_r <= s_axis_tlast;
    end
    case (state)
      S_EXEC: begin
        ma    <= ma_in;
        mb    <= mb_in;
        neg   <= opa[63] ^ opb[63];
        acc   <= '0;
        count <= '0;
        num   <= {ma_in[62:0], 30'b0};
        dv    <= mb_in;
        rem   <= '0;
        q     <= '0;
        if (uc.op == OP_SQRT) begin
          rad  <= nsq;
          root <= '0;
          srem <= '0;
        end
      end
      S_MUL: begin
        count <= count + 7'd1;
        pp    <= 64'(count[0] ? ma[63:32] : ma[31:0]) * 64'(count[1] ? mb[63:32] : mb[31:0]);
        pk    <= count[1:0];
        if (count != '0) begin
          acc <= acc + ({64'b0, pp} << {({1'b0, pk[0]} + {1'b0, pk[1]}), 5'b0});
        end
      end
      S_DIV: begin
        count <= count + 7'd1;
        num   <= {num[91:0], 1'b0};
        if (rem_sh >= {1'b0, dv}) begin
          rem <= 64'(rem_sh - {1'b0, dv});
          q   <= {q[91:0], 1'b1};
        end else begin
          rem <= rem_sh[63:0];
          q   <= {q[91:0], 1'b0};
        end
      end
      S_SQRT: begin
        count <= count + 7'd1;
        rad   <= {rad[93:0], 2'b00};
        if (ssh >= trial) begin
          srem <= 50'(ssh - trial);
          root <= {root[46:0], 1'b1};
        end else begin
          srem <= ssh[49:0];
          root <= {root[46:0], 1'b0};
        end
      end
      S_WB: begin
        case (uc.op)
          OP_TOLX: tol_flag <= above;
          OP_TOLY: tol_flag <= tol_flag | above;
          OP_SQA:  nsq <= NSQ_BASE + acc[95:0];
          OP_SQB:  nsq <= nsq + acc[95:0];
          OP_DIV: begin
            case (uc.lane)
              LANE_B:  res_b <= divres[31:0];
              LANE_H:  res_h <= divres[31:0];
              LANE_V:  res_v <= divres[31:0];
              default: ;
            endcase
          end
          default: ;
        endcase
      end
      default: ;
    endcase
    if (emit_go) begin
      m_axis_tdata <= {res_v, res_h, res_b};
      m_axis_tuser <= singular_r;
      m_axis_tlast <= last_r;
    end
  end

  a_start: assert property (@(posedge clk) disable iff (rst)
    (s_axis_tvalid && s_axis_tready) |=> (pc == '0 && state == S_READ))
    else $error("sequencer did not restart on accepted word");

  a_pc_range: assert property (@(posedge clk) disable iff (rst)
    (state != S_IDLE) |-> (pc <= L_LAST))
    else $error("micro-op counter out of range");

  a_iter_bound: assert property (@(posedge clk) disable iff (rst)
    (state != S_IDLE) |-> (iter <= iter_limit))
    else $error("Newton step count passed its limit");

  a_emit_src: assert property (@(posedge clk) disable iff (rst)
    $rose(m_axis_tvalid) |-> $past(state == S_EXEC && uc.op == OP_EMIT))
    else $error("result word raised outside emit step");

  a_div_count: assert property (@(posedge clk) disable iff (rst)
    (state == S_DIV) |-> (count <= DIV_LAST))
    else $error("divider ran past its last quotient bit");

endmodule

`default_nettype wire

// File: sim/tb_top.sv
// Self-checking testbench for radial_undistort_unit_vector: drives centroid words,
// predicts each unit vector with a local fixed-point Newton model and compares.
// Depends on rudv_pkg (register indexes) and the block itself.
`default_nettype none

module tb_top;
  timeunit 1ns;
  timeprecision 1ps;
  import rudv_pkg::*;

  localparam logic [63:0] SAT = 64'h3FFF_FFFF_FFFF_FFFF;
  localparam logic signed [63:0] TANL = 64'sh0000_4000_0000_0000;
  localparam logic signed [63:0] Q30 = 64'sh4000_0000;
  localparam int WATCHDOG = 200000;

  typedef struct {
    logic [31:0] bore;
    logic [31:0] horiz;
    logic [31:0] vert;
    logic        sing;
    logic        last;
  } uvec_t;

  logic        clk = 0;
  logic        rst = 1;
  logic        s_axis_tvalid = 0;
  logic        s_axis_tready;
  logic [39:0] s_axis_tdata = '0;
  logic        s_axis_tlast = 0;
  logic        m_axis_tvalid;
  logic        m_axis_tready = 0;
  logic [95:0] m_axis_tdata;
  logic [0:0]  m_axis_tuser;
  logic        m_axis_tlast;
  logic        cfg_valid = 0;
  logic        cfg_ready;
  logic [2:0]  cfg_index = '0;
  logic [31:0] cfg_data = '0;

  radial_undistort_unit_vector i_dut (
    .clk, .rst, .s_axis_tvalid, .s_axis_tready, .s_axis_tdata, .s_axis_tlast,
    .m_axis_tvalid, .m_axis_tready, .m_axis_tdata, .m_axis_tuser, .m_axis_tlast,
    .cfg_valid, .cfg_ready, .cfg_index, .cfg_data
  );

  // local copy of the calibration registers
  logic [11:0] cen_col, cen_row;
  logic [31:0] pix_scale;
  logic signed [63:0] k1, k2;
  logic [5:0]  step_cap;
  logic [15:0] tol_sq;

  uvec_t expected_vecs[$];
  int    fails = 0;
  int    src_idle = 0;
  int    snk_idle = 0;
  bit    hold_sink = 0;
  int    quiet = 0;

  initial forever #5 clk = ~clk;

  function automatic logic [63:0] absval(logic signed [63:0] a);
    return a[63] ? 64'(-a) : 64'(a);
  endfunction

  function automatic logic signed [63:0] clip(logic [127:0] m, bit neg);
    logic [63:0] v;
    v = (m > {64'd0, SAT}) ? SAT : m[63:0];
    return neg ? -$signed(v) : $signed(v);
  endfunction

  function automatic logic signed [63:0] prod(logic signed [63:0] a, logic signed [63:0] b,
                                              int s);
    logic [127:0] p;
    p = {64'd0, absval(a)} * {64'd0, absval(b)};
    return clip(p >> s, a[63] ^ b[63]);
  endfunction

  function automatic logic signed [63:0] sum(logic signed [63:0] a, logic signed [63:0] b);
    logic signed [63:0] s;
    s = a + b;
    if (s > $signed(SAT)) return $signed(SAT);
    if (s < -$signed(SAT)) return -$signed(SAT);
    return s;
  endfunction

  function automatic logic signed [63:0] quot(logic signed [63:0] n, logic signed [63:0] d,
                                              int s);
    logic [127:0] q;
    if (d == 0) return 0;
    q = ({64'd0, absval(n)} << s) / {64'd0, absval(d)};
    return clip(q, n[63] ^ d[63]);
  endfunction

  function automatic bit over_tol(logic signed [63:0] f);
    logic [127:0] p;
    p = {64'd0, absval(f)} * {64'd0, absval(f)};
    return p > ({112'd0, tol_sq} << 16);
  endfunction

  function automatic logic signed [63:0] clamp_tan(logic signed [63:0] t);
    return t > TANL ? TANL : (t < -TANL ? -TANL : t);
  endfunction

  function automatic uvec_t undistort(logic [19:0] row, logic [19:0] col, logic last);
    logic signed [63:0] xd, yd, x, y, xx, xy, yy, r, g, fx, fy, tx, ty;
    logic signed [63:0] h, j0, j1, j3, det, nx, ny, nrm;
    logic [127:0] nsq, c2;
    logic [63:0] rt, cand;
    int iter;
    uvec_t v;
    xd = ($signed({52'd0, cen_col}) * 256 - $signed({44'd0, col})) * 256;
    yd = ($signed({52'd0, cen_row}) * 256 - $signed({44'd0, row})) * 256;
    x = xd;
    y = yd;
    iter = 0;
    v.sing = 0;
    while (1) begin
      xx = prod(x, x, 16);
      xy = prod(x, y, 16);
      yy = prod(y, y, 16);
      r = sum(xx, yy);
      g = sum(sum(Q30, prod(k1, r, 26)), prod(k2, prod(r, r, 32), 42));
      fx = sum(prod(g, x, 30), -xd);
      fy = sum(prod(g, y, 30), -yd);
      if (!(over_tol(fx) || over_tol(fy)) || iter >= step_cap) break;
      h = sum(k1 * 512, prod(k2, r, 38));
      j0 = sum(g, prod(h, xx, 34));
      j1 = prod(h, xy, 34);
      j3 = sum(g, prod(h, yy, 34));
      det = sum(prod(j0, j3, 30), -prod(j1, j1, 30));
      if (det == 0) begin
        v.sing = 1;
        break;
      end
      nx = sum(prod(j3, fx, 30), -prod(j1, fy, 30));
      ny = sum(prod(j0, fy, 30), -prod(j1, fx, 30));
      x = sum(x, -quot(nx, det, 30));
      y = sum(y, -quot(ny, det, 30));
      iter++;
    end
    tx = clamp_tan(prod($signed({32'd0, pix_scale}), x, 18));
    ty = clamp_tan(prod($signed({32'd0, pix_scale}), y, 18));
    nsq = (128'd1 << 60) + {64'd0, absval(tx)} * {64'd0, absval(tx)}
          + {64'd0, absval(ty)} * {64'd0, absval(ty)};
    rt = 0;
    for (int b = 47; b >= 0; b--) begin
      cand = rt | (64'd1 << b);
      c2 = {64'd0, cand} * {64'd0, cand};
      if (c2 <= nsq) rt = cand;
    end
    nrm = $signed(rt);
    v.bore = 32'(quot(Q30, nrm, 30));
    v.horiz = 32'(quot(tx, nrm, 30));
    v.vert = 32'(quot(ty, nrm, 30));
    v.last = last;
    return v;
  endfunction

  always @(negedge clk) begin
    if (hold_sink) m_axis_tready <= 0;
    else m_axis_tready <= ($urandom_range(99) >= snk_idle);
  end

  always @(posedge clk) begin
    uvec_t e;
    if (!rst && m_axis_tvalid && m_axis_tready) begin
      if (expected_vecs.size() == 0) begin
        $display("%0t: unexpected word %h singular %b last %b", $time, m_axis_tdata,
                 m_axis_tuser, m_axis_tlast);
        fails++;
      end else begin
        e = expected_vecs.pop_front();
        if (m_axis_tdata !== {e.vert, e.horiz, e.bore} || m_axis_tuser[0] !== e.sing ||
            m_axis_tlast !== e.last) begin
          $display("%0t: expected %h %h %h sing %b last %b, got %h %h %h sing %b last %b",
                   $time, e.vert, e.horiz, e.bore, e.sing, e.last, m_axis_tdata[95:64],
                   m_axis_tdata[63:32], m_axis_tdata[31:0], m_axis_tuser, m_axis_tlast);
          fails++;
        end
      end
    end
  end

  always @(posedge clk) begin
    if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready) ||
        (cfg_valid && cfg_ready) || rst)
      quiet <= 0;
    else quiet <= quiet + 1;
    if (quiet >= WATCHDOG) begin
      $display("radial_undistort_unit_vector: mismatch");
      $finish;
    end
  end

  task automatic write_reg(cfg_reg_t idx, logic [31:0] val);
    cfg_valid = 1;
    cfg_index = idx;
    cfg_data = val;
    do @(posedge clk); while (!cfg_ready);
    case (idx)
      REG_CENTRE_COL: cen_col = val[11:0];
      REG_CENTRE_ROW: cen_row = val[11:0];
      REG_PIXEL_SCALE: pix_scale = val;
      REG_K1_COEF: k1 = $signed(val);
      REG_K2_COEF: k2 = $signed(val);
      REG_ITER_LIMIT: step_cap = val[5:0];
      default: tol_sq = val[15:0];
    endcase
    @(negedge clk);
    cfg_valid = 0;
  endtask

  task automatic configure(logic [11:0] cc, logic [11:0] cr, logic [31:0] ps,
                           logic [31:0] c1, logic [31:0] c2, logic [5:0] il, logic [15:0] tl);
    write_reg(REG_CENTRE_COL, 32'(cc));
    write_reg(REG_CENTRE_ROW, 32'(cr));
    write_reg(REG_PIXEL_SCALE, ps);
    write_reg(REG_K1_COEF, c1);
    write_reg(REG_K2_COEF, c2);
    write_reg(REG_ITER_LIMIT, 32'(il));
    write_reg(REG_RESIDUAL_TOL_SQ, 32'(tl));
  endtask

  task automatic send_centroid(logic [19:0] row, logic [19:0] col, logic last);
    while ($urandom_range(99) < src_idle) begin
      s_axis_tvalid = 0;
      @(negedge clk);
    end
    s_axis_tvalid = 1;
    s_axis_tdata = {col, row};
    s_axis_tlast = last;
    do @(posedge clk); while (!s_axis_tready);
    expected_vecs.push_back(undistort(row, col, last));
    @(negedge clk);
  endtask

  task automatic drain();
    s_axis_tvalid = 0;
    while (expected_vecs.size() != 0) @(negedge clk);
    repeat (20) @(negedge clk);
  endtask

  task automatic test_reset_defaults();
    send_centroid(20'h00000, 20'h00000, 0);
    send_centroid(20'hFFFFF, 20'hFFFFF, 1);
    send_centroid(20'h12345, 20'hABCDE, 0);
    drain();
  endtask

  task automatic test_directed();
    // realistic lens, exact tolerance, full iteration budget
    configure(12'd2048, 12'd1536, 32'd2097152, 32'hFFFF_F000, 32'd64, 6'd63, 16'd0);
    send_centroid(20'h00000, 20'h00000, 0);
    send_centroid(20'hFFFFF, 20'hFFFFF, 0);
    send_centroid(20'h60000, 20'h80000, 1);
    drain();
    // no correction
    configure(12'd4095, 12'd0, 32'hFFFF_FFFF, 32'h7FFF_FFFF, 32'h8000_0000, 6'd0, 16'hFFFF);
    send_centroid(20'h00000, 20'hFFFFF, 0);
    send_centroid(20'hFFFFF, 20'h00000, 1);
    drain();
    // zero pixel scale
    configure(12'd100, 12'd200, 32'd0, 32'd1000, 32'd0, 6'd3, 16'd1);
    send_centroid(20'h00100, 20'hF0000, 1);
    drain();
    // huge coefficients saturate the Jacobian and drive the determinant to zero
    configure(12'd4095, 12'd4095, 32'd4096, 32'h7FFF_FFFF, 32'h7FFF_FFFF, 6'd5, 16'd0);
    send_centroid(20'h00000, 20'h00000, 0);
    send_centroid(20'h00000, 20'hFFFFF, 1);
    drain();
    configure(12'd0, 12'd4095, 32'h8000_0000, 32'h8000_0000, 32'h8000_0000, 6'd5, 16'd0);
    send_centroid(20'hFFFFF, 20'hFFFFF, 0);
    send_centroid(20'h00000, 20'h7FFFF, 1);
    drain();
  endtask

  task automatic random_config();
    logic [31:0] c1, c2, ps;
    c1 = $urandom;
    c2 = $urandom;
    ps = $urandom;
    if ($urandom_range(2) != 0) c1 = $signed(c1) >>> $urandom_range(31, 8);
    if ($urandom_range(2) != 0) c2 = $signed(c2) >>> $urandom_range(31, 4);
    if ($urandom_range(1) != 0) ps = ps >> $urandom_range(24, 8);
    configure(12'($urandom), 12'($urandom), ps, c1, c2, 6'($urandom_range(2)),
              16'($urandom));
  endtask

  task automatic test_random(int n, int si, int ki);
    src_idle = si;
    snk_idle = ki;
    random_config();
    for (int i = 0; i < n; i++) begin
      send_centroid(20'($urandom), 20'($urandom), 1'($urandom_range(1)));
      if (i % 40 == 39) begin
        drain();
        random_config();
      end
    end
    drain();
  endtask

  task automatic test_backpressure();
    src_idle = 0;
    snk_idle = 0;
    random_config();
    @(posedge clk);
    hold_sink = 1;
    fork
      begin
        repeat (3000) @(posedge clk);
        hold_sink = 0;
      end
    join_none
    @(negedge clk);
    for (int i = 0; i < 6; i++) send_centroid(20'($urandom), 20'($urandom), i == 5);
    drain();
    for (int i = 0; i < 4; i++)
      send_centroid(20'($urandom), 20'($urandom), 1'($urandom_range(1)));
    drain();
  endtask

  initial begin
    cen_col = 0; cen_row = 0; pix_scale = 0; k1 = 0; k2 = 0;
    step_cap = 6'd50; tol_sq = 0;
    repeat (5) @(posedge clk);
    rst <= 0;
    @(negedge clk);
    test_reset_defaults();
    test_directed();
    test_random(140, 0, 0);
    test_random(140, 69, 0);
    test_random(140, 0, 69);
    test_random(140, 15, 15);
    test_backpressure();
    if (fails == 0) $display("radial_undistort_unit_vector: match");
    else $display("radial_undistort_unit_vector: mismatch");
    $finish;
  end
endmodule

`default_nettype wire
